// ===== rtl/pip_pkg.sv =====
`default_nettype none

package pip_pkg;

   localparam int OPCODE_WIDTH = 2;

   typedef logic [OPCODE_WIDTH-1:0] opcode_type;

   localparam opcode_type OP_CLEAR  = 2'd0;
   localparam opcode_type OP_APPEND = 2'd1;
   localparam opcode_type OP_QUERY  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/pip_req_if.sv =====
`default_nettype none

interface pip_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   pip_pkg::opcode_type           opcode;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;

   modport source (output valid, output opcode, output coord_x, output coord_y,
                   input ready);
   modport sink   (input valid, input opcode, input coord_x, input coord_y,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/pip_rsp_if.sv =====
`default_nettype none

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic vertices_dropped;

   modport source (output valid, output inside_res, output vertices_dropped,
                   input ready);
   modport sink   (input valid, input inside_res, input vertices_dropped,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/pip_vstore.sv =====
`default_nettype none

// Vertex memory: one write port, one read port, registered read data.
module pip_vstore #(
   parameter int DEPTH       = 64,
   parameter int ADDR_WIDTH  = 6,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_WIDTH-1:0]         wr_addr,
   input  wire logic signed [COORD_WIDTH-1:0] wr_x,
   input  wire logic signed [COORD_WIDTH-1:0] wr_y,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_WIDTH-1:0]         rd_addr,
   output logic signed [COORD_WIDTH-1:0]      rd_x,
   output logic signed [COORD_WIDTH-1:0]      rd_y
);

   logic signed [COORD_WIDTH-1:0] mem_x [DEPTH];
   logic signed [COORD_WIDTH-1:0] mem_y [DEPTH];
   logic signed [COORD_WIDTH-1:0] rd_x_ff;
   logic signed [COORD_WIDTH-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

`default_nettype wire

// ===== rtl/pip_mul.sv =====
`default_nettype none

// Shared signed multiplier, product registered.
module pip_mul #(
   parameter int OP_WIDTH = 17
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic signed [OP_WIDTH-1:0]   op_a,
   input  wire logic signed [OP_WIDTH-1:0]   op_b,
   output logic signed [2*OP_WIDTH-1:0]      prod
);

   logic signed [2*OP_WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/point_in_polygon_test.sv =====
`default_nettype none

// Channel   Dir  Handshake        Payload
// req_if    in   valid / ready    opcode, coord_x, coord_y
// rsp_if    out  valid / ready    inside_res, vertices_dropped
//
// Clear and append transactions give no response.
// A query first primes the three-vertex window, then walks each stored edge
// through ST_DIFF, ST_MUL_A, ST_MUL_B and ST_SUM, since the single multiplier is
// used twice per edge. With no stored vertices the response is set on acceptance.
// Synchronous active-high reset empties the store and clears the drop flag.
// req_if.ready is low while a query runs and while an earlier response
// is held and not being taken.
module point_in_polygon_test #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pip_req_if.sink    req_if,
   pip_rsp_if.source  rsp_if
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int DW = COORD_WIDTH + 1;      // coordinate difference
   localparam int PW = 2 * DW;               // product
   localparam int SW = PW + 1;               // sum of two products

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_MUL_A = 3'd3;
   localparam logic [2:0] ST_MUL_B = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;

   localparam logic [1:0] PRIME_LAST = 2'd3;

   // control state
   logic [2:0]    state_ff,     state_in;
   logic [CW-1:0] vcount_ff,    vcount_in;
   logic          ovf_ff,       ovf_in;
   logic [AW-1:0] rd_ptr_ff,    rd_ptr_in;
   logic [AW-1:0] edge_ff,      edge_in;
   logic [1:0]    prime_ff,     prime_in;
   logic          parity_ff,    parity_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [COORD_WIDTH-1:0] pt_x_ff, pt_y_ff;
   logic signed [COORD_WIDTH-1:0] wx_i_ff, wy_i_ff, wx_j_ff, wy_j_ff, wx_s_ff, wy_s_ff;
   logic signed [DW-1:0]          d_ay_ff, d_bx_ff, d_by_ff, d_px_ff;
   logic                          count_ok_ff, back_ff;
   logic signed [PW-1:0]          prod1_ff;
   logic                          inside_ff, dropped_ff;

   logic                          req_fire;
   logic                          wr_en, rd_en, shift_en;
   logic                          load_pt, load_diff, rsp_set;
   logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
   logic [AW-1:0]                 rd_ptr_next;
   logic                          edge_last;

   logic signed [DW-1:0]          xi_e, yi_e, xj_e, yj_e, px_e, py_e;
   logic signed [DW-1:0]          ax_e, ay_e, bx_e, by_e;
   logic                          in_span, x_lt;
   logic                          mul_en;
   logic signed [DW-1:0]          mul_a, mul_b;
   logic signed [PW-1:0]          prod;
   logic signed [SW-1:0]          sum;
   logic                          crosses;

   assign req_fire      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);

   assign wr_en = req_fire && (req_if.opcode == pip_pkg::OP_APPEND)
                  && (vcount_ff < CW'(MAX_VERTICES));

   // read pointer walks 0..n-1 and wraps
   assign rd_ptr_next = ((CW'(rd_ptr_ff) + CW'(1)) == vcount_ff) ? '0 : rd_ptr_ff + AW'(1);
   assign edge_last   = (CW'(edge_ff) + CW'(1)) == vcount_ff;

   pip_vstore #(
      .DEPTH       (MAX_VERTICES),
      .ADDR_WIDTH  (AW),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (vcount_ff[AW-1:0]),
      .wr_x    (req_if.coord_x),
      .wr_y    (req_if.coord_y),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   // edge geometry, window holds vertices i, j = i+1, s = i+2
   always_comb begin
      xi_e = $signed({wx_i_ff[COORD_WIDTH-1], wx_i_ff});
      yi_e = $signed({wy_i_ff[COORD_WIDTH-1], wy_i_ff});
      xj_e = $signed({wx_j_ff[COORD_WIDTH-1], wx_j_ff});
      yj_e = $signed({wy_j_ff[COORD_WIDTH-1], wy_j_ff});
      px_e = $signed({pt_x_ff[COORD_WIDTH-1], pt_x_ff});
      py_e = $signed({pt_y_ff[COORD_WIDTH-1], pt_y_ff});
      in_span = ((wx_i_ff <= pt_x_ff) && (wx_j_ff >= pt_x_ff))
             || ((wx_i_ff >= pt_x_ff) && (wx_j_ff <= pt_x_ff));
      x_lt = wx_i_ff < wx_j_ff;
      // a = left end, b = right end
      ax_e = x_lt ? xi_e : xj_e;
      ay_e = x_lt ? yi_e : yj_e;
      bx_e = x_lt ? xj_e : xi_e;
      by_e = x_lt ? yj_e : yi_e;
   end

   // (ay-py)*(bx-ax) first, then (by-ay)*(px-ax), on the one multiplier
   assign mul_en = (state_ff == ST_MUL_A) || (state_ff == ST_MUL_B);
   assign mul_a  = (state_ff == ST_MUL_A) ? d_ay_ff : d_by_ff;
   assign mul_b  = (state_ff == ST_MUL_A) ? d_bx_ff : d_px_ff;

   pip_mul #(
      .OP_WIDTH (DW)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign sum     = $signed({prod1_ff[PW-1], prod1_ff}) + $signed({prod[PW-1], prod});
   assign crosses = count_ok_ff && !sum[SW-1];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      ovf_in       = ovf_ff;
      rd_ptr_in    = rd_ptr_ff;
      edge_in      = edge_ff;
      prime_in     = prime_ff;
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rd_en        = 1'b0;
      shift_en     = 1'b0;
      load_pt      = 1'b0;
      load_diff    = 1'b0;
      rsp_set      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.opcode)
                  pip_pkg::OP_CLEAR: begin
                     vcount_in = '0;
                     ovf_in    = 1'b0;
                  end
                  pip_pkg::OP_APPEND: begin
                     if (wr_en) begin
                        vcount_in = vcount_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  pip_pkg::OP_QUERY: begin
                     load_pt   = 1'b1;
                     parity_in = 1'b0;
                     rd_ptr_in = '0;
                     edge_in   = '0;
                     prime_in  = '0;
                     if (vcount_ff == '0) begin
                        rsp_set = 1'b1;
                     end else begin
                        state_in = ST_PRIME;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRIME: begin
            // three reads in flight, each shifted into the window on the next cycle
            if (prime_ff != PRIME_LAST) begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_next;
            end
            shift_en = prime_ff != 2'd0;
            prime_in = prime_ff + 2'd1;
            if (prime_ff == PRIME_LAST) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            rd_en     = 1'b1;
            rd_ptr_in = rd_ptr_next;
            load_diff = 1'b1;
            state_in  = ST_MUL_A;
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            shift_en = 1'b1;
            if (crosses) begin
               // counted edge through a vertex at px with its neighbours
               // on opposite sides: undo the count
               parity_in = parity_ff ^ !back_ff;
            end
            if (edge_last) begin
               rsp_set  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               edge_in  = edge_ff + AW'(1);
               state_in = ST_DIFF;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         ovf_ff       <= 1'b0;
         rd_ptr_ff    <= '0;
         edge_ff      <= '0;
         prime_ff     <= '0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         ovf_ff       <= ovf_in;
         rd_ptr_ff    <= rd_ptr_in;
         edge_ff      <= edge_in;
         prime_ff     <= prime_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_pt) begin
         pt_x_ff <= req_if.coord_x;
         pt_y_ff <= req_if.coord_y;
      end
      if (shift_en) begin
         wx_i_ff <= wx_j_ff;
         wy_i_ff <= wy_j_ff;
         wx_j_ff <= wx_s_ff;
         wy_j_ff <= wy_s_ff;
         wx_s_ff <= rd_x;
         wy_s_ff <= rd_y;
      end
      if (load_diff) begin
         d_ay_ff     <= ay_e - py_e;
         d_bx_ff     <= bx_e - ax_e;
         d_by_ff     <= by_e - ay_e;
         d_px_ff     <= px_e - ax_e;
         count_ok_ff <= in_span && (wx_i_ff != wx_j_ff);
         back_ff     <= (wx_j_ff == pt_x_ff)
                        && ((wx_s_ff < pt_x_ff) != (wx_i_ff < pt_x_ff));
      end
      if (state_ff == ST_MUL_B) begin
         prod1_ff <= prod;
      end
      if (rsp_set) begin
         inside_ff  <= (state_ff == ST_SUM) ? parity_in : 1'b0;
         dropped_ff <= ovf_ff;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.inside_res       = inside_ff;
   assign rsp_if.vertices_dropped = dropped_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

// Self-checking bench for the crossing-parity point-in-polygon block.
// A directed opening walks a short stimulus table; a long random phase then
// builds polygons and queries them. Every query transaction accepted on the
// request channel has a typed or predicted answer checked with the response.
module tb;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_WIDTH  = 16;
   localparam int ITEM_TARGET  = 1400;
   // No idling once this many transactions have gone in
   localparam int CALM_FROM    = 1250;
   // Margin allowed after the last response, beyond the longest query
   localparam int DRAIN_CYCLES = 300;

   // The one opcode that the package leaves unnamed: the block ignores it
   localparam pip_pkg::opcode_type OP_UNUSED = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic in_poly;
      logic dropped;
   } answer_type;

   // Answer booked by the stimulus for a query: typed in, or left to the predictor
   typedef struct packed {
      logic       known;
      answer_type ans;
   } booking_type;

   typedef struct {
      pip_pkg::opcode_type op;
      int                  x;
      int                  y;
      bit                  known;
      bit                  in_poly;
      bit                  dropped;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pip_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_ch ();
   pip_rsp_if                              rsp_ch ();

   point_in_polygon_test #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: our own copy of the vertex store and drop flag
   // ---------------------------------------------------------------
   coord_type poly_x [MAX_VERTICES];
   coord_type poly_y [MAX_VERTICES];
   int        poly_count = 0;
   bit        drop_flag  = 1'b0;

   answer_type  awaited_answers [$];   // responses still to come, oldest first
   booking_type booked_answers  [$];   // one per query transaction sent

   int  error_count     = 0;
   int  queries_checked = 0;
   int  drop_answers    = 0;
   int  inside_answers  = 0;
   int  items_sent      = 0;
   bit  calm            = 1'b0;    // set near the end: no idling on either side
   int  idle_odds       = 4;       // 1-in-N chance of a gap before a request; 0 = none

   // Vertical-ray crossing parity. An edge counts when it is not vertical,
   // the point lies in its closed x span and the edge's height at px is at
   // or above py. Height is compared by cross-multiplying, so no division.
   // A counted edge ending on a vertex at px, where the walk passes through
   // that vertex, is taken back once to repair the double count.
   function automatic bit crossing_parity(coord_type px, coord_type py);
      longint lpx, lpy, xi, yi, xj, yj, xs, ax, ay, bx, by;
      int     j, s;
      bit     parity;
      bit     in_span;
      lpx    = px;
      lpy    = py;
      parity = 1'b0;
      for (int i = 0; i < poly_count; i++) begin
         j  = (i + 1 < poly_count) ? i + 1 : 0;
         s  = (j + 1 < poly_count) ? j + 1 : 0;
         xi = poly_x[i];
         yi = poly_y[i];
         xj = poly_x[j];
         yj = poly_y[j];
         xs = poly_x[s];
         in_span = (xi <= lpx && xj >= lpx) || (xi >= lpx && xj <= lpx);
         if (in_span && xi != xj) begin
            if (xi < xj) begin
               ax = xi; ay = yi; bx = xj; by = yj;
            end else begin
               ax = xj; ay = yj; bx = xi; by = yi;
            end
            // 17-bit differences, 34-bit products: comfortably inside 64 bits
            if ((ay - lpy) * (bx - ax) + (by - ay) * (lpx - ax) >= 0) begin
               parity ^= 1'b1;
               if (xj == lpx && ((xs < lpx) != (xi < lpx)))
                  parity ^= 1'b1;
            end
         end
      end
      return parity;
   endfunction

   // Update the predictor with one accepted request transaction
   task automatic take_request(pip_pkg::opcode_type op, coord_type cx, coord_type cy);
      answer_type  a;
      booking_type b;
      case (op)
         pip_pkg::OP_CLEAR: begin
            poly_count = 0;
            drop_flag  = 1'b0;
         end
         pip_pkg::OP_APPEND: begin
            if (poly_count < MAX_VERTICES) begin
               poly_x[poly_count] = cx;
               poly_y[poly_count] = cy;
               poly_count++;
            end else begin
               drop_flag = 1'b1;   // store full: vertex lost, flag sticks
            end
         end
         pip_pkg::OP_QUERY: begin
            a.in_poly = crossing_parity(cx, cy);
            a.dropped = drop_flag;
            b = booked_answers.pop_front();
            if (b.known)
               a = b.ans;
            awaited_answers = {awaited_answers, a};
         end
         default: begin
            // unused opcode: no state change, no response
         end
      endcase
   endtask

   // Compare one accepted response with the oldest awaited answer
   task automatic check_response(logic in_poly, logic dropped);
      answer_type a;
      if (awaited_answers.size() == 0) begin
         error_count++;
         $display("%0t: response with none awaited (inside_res=%0b vertices_dropped=%0b)",
                  $time, in_poly, dropped);
      end else begin
         a = awaited_answers.pop_front();
         queries_checked++;
         if (a.in_poly)
            inside_answers++;
         if (a.dropped)
            drop_answers++;
         if (in_poly !== a.in_poly) begin
            error_count++;
            $display("%0t: inside_res expected %0b actual %0b", $time, a.in_poly, in_poly);
         end
         if (dropped !== a.dropped) begin
            error_count++;
            $display("%0t: vertices_dropped expected %0b actual %0b",
                     $time, a.dropped, dropped);
         end
      end
   endtask

   // Monitor: both channels sampled at the rising edge, request first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            take_request(req_ch.opcode, req_ch.coord_x, req_ch.coord_y);
         if (rsp_ch.valid && rsp_ch.ready)
            check_response(rsp_ch.inside_res, rsp_ch.vertices_dropped);
      end
   end

   // Response sink: ready held low in random bursts, never once calm
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Drive one request transaction and wait for its acceptance. Valid is only
   // lowered for an idle burst, so back-to-back transactions keep it high.
   task automatic send_item(pip_pkg::opcode_type op, coord_type x, coord_type y,
                            bit known, answer_type ans);
      booking_type b;
      b.known = known;
      b.ans   = ans;
      if (op == pip_pkg::OP_QUERY)
         booked_answers = {booked_answers, b};
      if (op != OP_UNUSED)
         items_sent++;
      @(negedge clock);
      if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.opcode  <= op;
      req_ch.coord_x <= x;
      req_ch.coord_y <= y;
      do
         @(posedge clock);
      while (!req_ch.ready);
      calm = (items_sent >= CALM_FROM);
   endtask

   task automatic send_plain(pip_pkg::opcode_type op, coord_type x, coord_type y);
      send_item(op, x, y, 1'b0, answer_type'(0));
   endtask

   // Narrow coordinates pile up equal x values, vertical edges and vertex
   // hits; wide ones exercise the full signed range and the extremes.
   function automatic coord_type pick_coord(bit narrow);
      int v;
      if (narrow) begin
         v = $urandom_range(0, 40);
         return coord_type'(v - 20);
      end
      case ($urandom_range(0, 9))
         0:       return coord_type'(16'h8000);
         1:       return coord_type'(16'h7fff);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Opening table: extremes, every opcode, the single-vertex and empty
   // store, vertical edges and rays passing through a vertex. The typed
   // answers are the ones obvious on sight; the rest go to the predictor.
   row_type opening_rows [25] = '{
      '{pip_pkg::OP_QUERY,       0,      0, 1'b1, 1'b0, 1'b0},   // empty after reset
      '{OP_UNUSED,              -1,     -1, 1'b0, 1'b0, 1'b0},   // ignored
      '{pip_pkg::OP_APPEND, -32768, -32768, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_APPEND,  32767, -32768, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_APPEND,  32767,  32767, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_APPEND, -32768,  32767, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_QUERY,       0,      0, 1'b1, 1'b1, 1'b0},   // centre of full square
      '{pip_pkg::OP_QUERY,  -32768,      0, 1'b0, 1'b0, 1'b0},   // on left vertical edge
      '{pip_pkg::OP_QUERY,   32767, -32768, 1'b0, 1'b0, 1'b0},   // corner
      '{pip_pkg::OP_QUERY,       0,  32767, 1'b0, 1'b0, 1'b0},   // on top edge
      '{pip_pkg::OP_QUERY,       0, -32768, 1'b0, 1'b0, 1'b0},   // on bottom edge
      '{pip_pkg::OP_CLEAR,       0,      0, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_QUERY,       5,      5, 1'b1, 1'b0, 1'b0},   // empty after clear
      '{pip_pkg::OP_APPEND,      0,     10, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_QUERY,       0,      0, 1'b1, 1'b0, 1'b0},   // one vertex: no edge
      '{pip_pkg::OP_APPEND,     10,    -10, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_QUERY,       0,      0, 1'b0, 1'b0, 1'b0},   // two vertices
      '{pip_pkg::OP_APPEND,    -10,    -10, 1'b0, 1'b0, 1'b0},
      '{pip_pkg::OP_QUERY,       0,      0, 1'b0, 1'b0, 1'b0},   // ray through apex
      '{pip_pkg::OP_QUERY,       0,    -20, 1'b0, 1'b0, 1'b0},   // through base and apex
      '{pip_pkg::OP_QUERY,      20,      0, 1'b0, 1'b0, 1'b0},   // outside span
      '{pip_pkg::OP_APPEND,    -10,     30, 1'b0, 1'b0, 1'b0},   // adds a vertical edge
      '{pip_pkg::OP_QUERY,     -10,      0, 1'b0, 1'b0, 1'b0},   // on the vertical edge
      '{pip_pkg::OP_QUERY,      -5,      0, 1'b0, 1'b0, 1'b0},
      '{OP_UNUSED,           32767,  32767, 1'b0, 1'b0, 1'b0}    // ignored, largest positive coordinates
   };

   // Stimulus
   initial begin
      coord_type  shape_x [$];
      coord_type  shape_y [$];
      answer_type typed;
      int         kind;
      int         size;
      int         queries;
      int         pick;
      int         polygons;
      bit         narrow;
      coord_type  qx;
      coord_type  qy;

      polygons        = 0;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = pip_pkg::OP_CLEAR;
      req_ch.coord_x  = '0;
      req_ch.coord_y  = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // --- directed opening ---
      foreach (opening_rows[r]) begin
         typed.in_poly = opening_rows[r].in_poly;
         typed.dropped = opening_rows[r].dropped;
         send_item(opening_rows[r].op, coord_type'(opening_rows[r].x),
                   coord_type'(opening_rows[r].y), opening_rows[r].known, typed);
      end

      // --- random phase: mostly well-formed polygon loads followed by queries ---
      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 15);
         if (kind == 0) begin
            // noise: ignored opcode, stray clear or a bare query on whatever is held
            case ($urandom_range(0, 2))
               0: send_plain(OP_UNUSED, coord_type'($urandom), coord_type'($urandom));
               1: begin
                  send_plain(pip_pkg::OP_CLEAR, coord_type'($urandom),
                             coord_type'($urandom));
                  shape_x.delete();
                  shape_y.delete();
               end
               default: send_plain(pip_pkg::OP_QUERY, pick_coord(1'b0), pick_coord(1'b0));
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 3;
               default: idle_odds = 6;
            endcase
            narrow = $urandom_range(0, 2) != 0;
            // now and then keep appending onto the previous polygon
            if ($urandom_range(0, 7) != 0) begin
               send_plain(pip_pkg::OP_CLEAR, coord_type'($urandom), coord_type'($urandom));
               shape_x.delete();
               shape_y.delete();
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
               size = $urandom_range(60, 70);   // can reach and overrun a full store
            else if (pick < 3)
               size = $urandom_range(0, 2);
            else
               size = $urandom_range(3, 12);
            repeat (size) begin
               qx = pick_coord(narrow);
               qy = pick_coord(narrow);
               shape_x = {shape_x, qx};
               shape_y = {shape_y, qy};
               send_plain(pip_pkg::OP_APPEND, qx, qy);
            end
            polygons++;
            queries = $urandom_range(2, 8);
            repeat (queries) begin
               pick = $urandom_range(0, 3);
               if (shape_x.size() != 0 && pick == 1) begin
                  // same x as a vertex: vertex crossings and span edges
                  qx = shape_x[$urandom_range(0, shape_x.size() - 1)];
                  qy = pick_coord(narrow);
               end else if (shape_x.size() != 0 && pick == 2) begin
                  size = $urandom_range(0, shape_x.size() - 1);
                  qx = shape_x[size];
                  qy = shape_y[size];
               end else begin
                  qx = pick_coord(narrow);
                  qy = pick_coord(narrow);
               end
               send_plain(pip_pkg::OP_QUERY, qx, qy);
            end
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions sent over %0d random polygons; %0d queries checked",
               items_sent, polygons, queries_checked);
      $display("%0d answers inside, %0d with the drop flag set",
               inside_answers, drop_answers);
      if (error_count == 0 && awaited_answers.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of all-largest queries with full stalls
   initial begin
      #30000000;
      $display("%0t: timeout, %0d responses still awaited", $time, awaited_answers.size());
      $display("tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pip_pkg.sv
rtl/pip_req_if.sv
rtl/pip_rsp_if.sv
rtl/pip_vstore.sv
rtl/pip_mul.sv
rtl/point_in_polygon_test.sv
tb/sv/tb.sv
